[hdl/affinv_pkg.sv]
package affinv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int EL_W          = 32;
    localparam int OP_W          = 34;
    localparam int ADJ_W         = 65;
    localparam int ACC_W         = 100;
    localparam int MAG_W         = 98;
    localparam int Q_W           = 33;
    localparam int P_W           = 7;
    localparam int S_W           = 9;
    localparam int SPLIT         = 32;
    localparam int HEAD          = 16;
    localparam int DMIN_W        = 63;
    localparam logic [DMIN_W-1:0] DET_MIN_RST = 63'd281474977;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COF,
        ST_DET,
        ST_RECIP,
        ST_SCALE,
        ST_TRANS,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_NORM,
        RS_DIV
    } rstate_t;

    typedef struct packed {
        logic                   vld;
        logic                   clr;
        logic                   neg;
        logic                   sh;
        logic                   last;
        logic [1:0]             dst;
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
    } lane_op_t;

    typedef struct packed {
        logic       done;
        logic [1:0] dst;
    } lane_st_t;

    typedef struct packed {
        logic vld;
        logic neg;
        logic sing;
    } merge_st_t;

    // store indices {a, b, c, d} of cofactor a*b - c*d for adjugate entry (i, j)
    function automatic logic [15:0] cof_sel(input logic [1:0] i, input logic [1:0] j);
        logic [15:0] r;
        case ({i, j})
            4'b0000: r = {4'd4, 4'd8, 4'd5, 4'd7};
            4'b0001: r = {4'd2, 4'd7, 4'd1, 4'd8};
            4'b0010: r = {4'd1, 4'd5, 4'd2, 4'd4};
            4'b0100: r = {4'd5, 4'd6, 4'd3, 4'd8};
            4'b0101: r = {4'd0, 4'd8, 4'd2, 4'd6};
            4'b0110: r = {4'd2, 4'd3, 4'd0, 4'd5};
            4'b1000: r = {4'd3, 4'd7, 4'd4, 4'd6};
            4'b1001: r = {4'd1, 4'd6, 4'd0, 4'd7};
            4'b1010: r = {4'd0, 4'd4, 4'd1, 4'd3};
            default: r = '0;
        endcase
        return r;
    endfunction

    // scale by 2^-s, round half away from zero, saturate to 32 bits
    function automatic logic [EL_W-1:0] to_q(input logic [ACC_W-1:0] v,
                                             input logic signed [S_W-1:0] s);
        logic                     neg;
        logic [ACC_W+HEAD-1:0]    m;
        logic [ACC_W+HEAD-1:0]    t;
        logic [ACC_W+HEAD-1:0]    half;
        logic [S_W-1:0]           ns;
        logic [EL_W-1:0]          r;
        neg  = v[ACC_W-1];
        m    = {{HEAD{1'b0}}, (neg ? (~v + 1'b1) : v)};
        ns   = -s;
        half = {{(ACC_W+HEAD-1){1'b0}}, 1'b1} << (s - 1'b1);
        if (s <= 0) begin
            t = m << ns;
        end
        else begin
            t = (m + half) >> s;
        end
        if (neg) begin
            if (t > (ACC_W+HEAD)'(64'h8000_0000)) begin
                r = 32'h8000_0000;
            end
            else begin
                r = ~t[EL_W-1:0] + 1'b1;
            end
        end
        else begin
            if (t > (ACC_W+HEAD)'(64'h7fff_ffff)) begin
                r = 32'h7fff_ffff;
            end
            else begin
                r = t[EL_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

[hdl/affine_matrix_inverse.sv]
// 4x4 affine inverse in signed Q(32-FRAC_BITS).FRAC_BITS. Rows 0..2 are written one word per
// cycle and give no result; the row 3 word starts the inverse, and no new input word is taken
// until all four result rows have been taken. Three multiply lanes with 34x34 multipliers do
// the cofactors, the determinant (plus one merge register), the scaled adjugate and the
// translation. Between them a bit-serial reciprocal unit takes a leading-one search plus 34
// divide steps. A singular matrix skips the reciprocal, scaling and translation and goes
// straight to the identity after the determinant. det_min may be written at any time the
// block is idle.
module affine_matrix_inverse #(
    parameter int FRAC_BITS = affinv_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [103:0]                       s_tdata,   // in_row, in_col0, in_col1, in_col2
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [103:0]                       m_tdata,   // out_row, out_col0, out_col1, out_col2
    output logic                               m_tlast,
    output logic                               m_tuser,   // singular
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [affinv_pkg::DMIN_W-1:0]      cfg_data
);
    import affinv_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;
    logic [2:0]              step_reg;
    logic [2:0]              step_next;
    logic [EL_W-1:0]         store_reg [12];
    logic [ADJ_W-1:0]        adj_reg [3][3];
    logic [EL_W-1:0]         res_reg [4][3];
    logic [DMIN_W-1:0]       det_min_reg;
    logic [Q_W-1:0]          q_reg;
    logic signed [S_W-1:0]   s_reg;
    logic                    neg_reg;
    logic                    sing_reg;
    logic [1:0]              orow_reg;

    lane_op_t                ops [3];
    lane_st_t                lst [3];
    logic [2:0][ACC_W-1:0]   acc;
    merge_st_t               mst;
    logic [MAG_W-1:0]        mag;
    logic                    rstart;
    logic                    rdone;
    logic [Q_W-1:0]          rq;
    logic [P_W-1:0]          rp;
    logic                    in_acc;
    logic                    out_acc;
    logic [1:0]              in_row;
    logic [EL_W-1:0]         one;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign in_row  = s_tdata[1:0];
    assign one     = 32'd1 << FRAC_BITS;

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        affinv_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .op    (ops[l]),
            .st    (lst[l]),
            .acc   (acc[l])
        );
    end

    affinv_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (state_reg == ST_DET && lst[0].done),
        .acc     (acc),
        .det_min (det_min_reg),
        .st      (mst),
        .mag     (mag)
    );

    affinv_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rstart),
        .mag   (mag),
        .done  (rdone),
        .q     (rq),
        .p     (rp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc && in_row == 2'd3) state_next = ST_COF;
            ST_COF:   if (lst[0].done && lst[0].dst == 2'd2) state_next = ST_DET;
            ST_DET:   if (mst.vld) state_next = mst.sing ? ST_EMIT : ST_RECIP;
            ST_RECIP: if (rdone) state_next = ST_SCALE;
            ST_SCALE: if (lst[0].done && lst[0].dst == 2'd2) state_next = ST_TRANS;
            ST_TRANS: if (lst[0].done) state_next = ST_EMIT;
            ST_EMIT:  if (out_acc && orow_reg == 2'd3) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and lane operations
    always_comb
    begin
        logic [15:0] sel;
        logic [1:0]  i;
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = (state_reg == ST_EMIT);
        cfg_ready = 1'b1;
        rstart    = (state_reg == ST_DET) && mst.vld && !mst.sing;
        if (state_next != state_reg)
        begin
            step_next = '0;
        end
        else
        begin
            step_next = (step_reg == 3'd7) ? step_reg : step_reg + 1'b1;
        end
        for (int l = 0; l < 3; l++)
        begin
            sel    = cof_sel(step_reg[2:1], 2'(l));
            i      = step_reg[2:1];
            ops[l] = '0;
            case (state_reg)
                ST_COF:
                begin
                    if (step_reg < 3'd6)
                    begin
                        ops[l].vld  = 1'b1;
                        ops[l].clr  = !step_reg[0];
                        ops[l].neg  = step_reg[0];
                        ops[l].last = step_reg[0];
                        ops[l].dst  = i;
                        ops[l].a = OP_W'($signed(step_reg[0] ? store_reg[sel[7:4]]
                                                             : store_reg[sel[15:12]]));
                        ops[l].b = OP_W'($signed(step_reg[0] ? store_reg[sel[3:0]]
                                                             : store_reg[sel[11:8]]));
                    end
                end
                ST_DET:
                begin
                    // row 0 element times the adjugate column, low half then high half
                    if (step_reg < 3'd2)
                    begin
                        ops[l].vld  = 1'b1;
                        ops[l].clr  = !step_reg[0];
                        ops[l].sh   = step_reg[0];
                        ops[l].last = step_reg[0];
                        ops[l].a    = OP_W'($signed(store_reg[l]));
                        ops[l].b    = step_reg[0]
                                    ? OP_W'($signed(adj_reg[l][0][ADJ_W-1:SPLIT]))
                                    : {2'b00, adj_reg[l][0][SPLIT-1:0]};
                    end
                end
                ST_SCALE:
                begin
                    if (step_reg < 3'd6)
                    begin
                        ops[l].vld  = 1'b1;
                        ops[l].clr  = !step_reg[0];
                        ops[l].sh   = step_reg[0];
                        ops[l].neg  = neg_reg;
                        ops[l].last = step_reg[0];
                        ops[l].dst  = i;
                        ops[l].a    = step_reg[0]
                                    ? OP_W'($signed(adj_reg[i][l][ADJ_W-1:SPLIT]))
                                    : {2'b00, adj_reg[i][l][SPLIT-1:0]};
                        ops[l].b    = {1'b0, q_reg};
                    end
                end
                ST_TRANS:
                begin
                    if (step_reg < 3'd3)
                    begin
                        ops[l].vld  = 1'b1;
                        ops[l].clr  = (step_reg == 3'd0);
                        ops[l].neg  = 1'b1;
                        ops[l].last = (step_reg == 3'd2);
                        ops[l].a    = OP_W'($signed(res_reg[step_reg[1:0]][l]));
                        ops[l].b    = OP_W'($signed(store_reg[4'd9 + 4'(step_reg[1:0])]));
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            orow_reg    <= '0;
            det_min_reg <= DET_MIN_RST;
            for (int k = 0; k < 12; k++)
            begin
                store_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_valid && cfg_ready)
            begin
                det_min_reg <= cfg_data;
            end
            if (in_acc)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    store_reg[4'(in_row) * 4'd3 + 4'(c)] <= s_tdata[2 + c*EL_W +: EL_W];
                end
            end
            if (out_acc)
            begin
                orow_reg <= orow_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mst.vld && state_reg == ST_DET)
        begin
            neg_reg  <= mst.neg;
            sing_reg <= mst.sing;
            if (mst.sing)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        res_reg[r][c] <= (r == c) ? one : '0;
                    end
                end
            end
        end
        if (rdone)
        begin
            q_reg <= rq;
            s_reg <= S_W'(rp) + S_W'(Q_W-1) - S_W'(2*FRAC_BITS);
        end
        for (int l = 0; l < 3; l++)
        begin
            if (lst[l].done)
            begin
                case (state_reg)
                    ST_COF:   adj_reg[lst[l].dst][l] <= acc[l][ADJ_W-1:0];
                    ST_SCALE: res_reg[lst[l].dst][l] <= to_q(acc[l], s_reg);
                    ST_TRANS: res_reg[3][l] <= to_q(acc[l], S_W'(FRAC_BITS));
                    default: ;
                endcase
            end
        end
    end

    assign m_tdata = {6'b0, res_reg[orow_reg][2], res_reg[orow_reg][1],
                      res_reg[orow_reg][0], orow_reg};
    assign m_tlast = (orow_reg == 2'd3);
    assign m_tuser = sing_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while results pending");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("block not idle after last result row");

    a_sing_trans: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tdata[1:0] == 2'd3 |-> m_tdata[97:2] == '0)
        else $error("singular translation row not zero");

endmodule

[hdl/affinv_lane.sv]
module affinv_lane (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  affinv_pkg::lane_op_t                    op,
    output affinv_pkg::lane_st_t                    st,
    output logic [affinv_pkg::ACC_W-1:0]            acc
);
    import affinv_pkg::*;

    logic                     vld_reg;
    logic                     clr_reg;
    logic                     neg_reg;
    logic                     sh_reg;
    logic                     last_reg;
    logic [1:0]               dst_reg;
    logic signed [2*OP_W-1:0] prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         term;
    lane_st_t                 st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            st_reg  <= '0;
        end
        else
        begin
            vld_reg <= op.vld;
            st_reg  <= '{done: vld_reg & last_reg, dst: dst_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        clr_reg  <= op.clr;
        neg_reg  <= op.neg;
        sh_reg   <= op.sh;
        last_reg <= op.last;
        dst_reg  <= op.dst;
        prod_reg <= op.a * op.b;
        if (vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        term = ACC_W'(prod_reg);
        if (sh_reg)
        begin
            term = term << SPLIT;
        end
        if (neg_reg)
        begin
            term = ~term + 1'b1;
        end
        acc_next = (clr_reg ? '0 : acc_reg) + term;
    end

    assign st  = st_reg;
    assign acc = acc_reg;

endmodule

[hdl/affinv_merge.sv]
module affinv_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_vld,
    input  logic [2:0][affinv_pkg::ACC_W-1:0]     acc,
    input  logic [affinv_pkg::DMIN_W-1:0]         det_min,
    output affinv_pkg::merge_st_t                 st,
    output logic [affinv_pkg::MAG_W-1:0]          mag
);
    import affinv_pkg::*;

    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] absv;
    logic [MAG_W-1:0] mag_next;
    merge_st_t        st_reg;
    logic [MAG_W-1:0] mag_reg;

    always_comb
    begin
        sum      = acc[0] + acc[1] + acc[2];
        absv     = sum[ACC_W-1] ? (~sum + 1'b1) : sum;
        mag_next = absv[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg.vld  <= in_vld;
            st_reg.neg  <= sum[ACC_W-1];
            st_reg.sing <= (mag_next == '0) ||
                           (mag_next < {{(MAG_W-DMIN_W){1'b0}}, det_min});
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
    end

    assign st  = st_reg;
    assign mag = mag_reg;

endmodule

[hdl/affinv_recip.sv]
module affinv_recip (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [affinv_pkg::MAG_W-1:0]    mag,
    output logic                            done,
    output logic [affinv_pkg::Q_W-1:0]      q,
    output logic [affinv_pkg::P_W-1:0]      p
);
    import affinv_pkg::*;

    rstate_t          state_reg;
    rstate_t          state_next;
    logic [MAG_W-1:0] nm_reg;
    logic [MAG_W:0]   rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic [P_W-1:0]   cnt_reg;
    logic [5:0]       k_reg;
    logic             done_reg;
    logic [MAG_W:0]   r2;
    logic             ge;
    logic             norm_ok;
    logic             div_end;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            RS_IDLE: if (start) state_next = RS_NORM;
            RS_NORM: if (norm_ok) state_next = RS_DIV;
            RS_DIV:  if (div_end) state_next = RS_IDLE;
            default: state_next = RS_IDLE;
        endcase
    end

    always_comb
    begin
        norm_ok = nm_reg[MAG_W-1];
        div_end = (k_reg == 6'(Q_W));
        r2      = (k_reg == '0) ? rem_reg : (rem_reg << 1);
        ge      = (r2 >= {1'b0, nm_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == RS_DIV) && div_end;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            RS_IDLE:
            begin
                nm_reg  <= mag;
                cnt_reg <= '0;
            end
            RS_NORM:
            begin
                // leading-one search: coarse steps of eight, then single bits
                if (norm_ok)
                begin
                    rem_reg <= {2'b01, {(MAG_W-1){1'b0}}};
                    q_reg   <= '0;
                    k_reg   <= '0;
                end
                else if (nm_reg[MAG_W-1 -: 8] == '0)
                begin
                    nm_reg  <= nm_reg << 8;
                    cnt_reg <= cnt_reg + P_W'(8);
                end
                else
                begin
                    nm_reg  <= nm_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            RS_DIV:
            begin
                // final step only looks at the next bit for rounding
                if (div_end)
                begin
                    q_reg <= q_reg + Q_W'(ge);
                end
                else
                begin
                    rem_reg <= ge ? (r2 - {1'b0, nm_reg}) : r2;
                    q_reg   <= {q_reg[Q_W-2:0], ge};
                    k_reg   <= k_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign p    = P_W'(MAG_W-1) - cnt_reg;

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import affinv_pkg::*;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic        singular;
        logic        last;
    } inv_row_t;

    typedef logic signed [199:0] wide_t;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 600000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [DMIN_W-1:0] cfg_data;

    logic [31:0]       mat_store[12];
    logic [DMIN_W-1:0] thresh;
    inv_row_t          inv_rows_due[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int mismatches;
    int rows_checked;
    int words_sent;
    int inverses;
    int singulars;
    int cycles;

    affine_matrix_inverse dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // round half away from zero by 2^-sh, saturate to 32 bits
    function automatic logic [31:0] round_sat(input wide_t v, input int sh);
        logic [199:0] m;
        logic         neg;
        neg = v[199];
        m = neg ? -v : v;
        if (sh <= 0)
        begin
            m = m << (-sh);
        end
        else
        begin
            m = (m + (200'd1 << (sh - 1))) >> sh;
        end
        if (neg)
        begin
            return (m > 200'h8000_0000) ? 32'h8000_0000 : -m[31:0];
        end
        return (m > 200'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
    endfunction

    function automatic wide_t sx(input logic [31:0] v);
        return wide_t'(signed'(v));
    endfunction

    task automatic predict_inverse();
        wide_t        r[3][3];
        wide_t        t[3];
        wide_t        adj[3][3];
        wide_t        det;
        wide_t        prod;
        wide_t        acc;
        logic [199:0] mag;
        logic [199:0] q;
        logic [31:0]  res[4][3];
        logic         sing;
        int           p;
        inv_row_t     e;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r[i][j] = sx(mat_store[i*3+j]);
            end
            t[i] = sx(mat_store[9+i]);
        end
        adj[0][0] = r[1][1]*r[2][2] - r[1][2]*r[2][1];
        adj[0][1] = r[0][2]*r[2][1] - r[0][1]*r[2][2];
        adj[0][2] = r[0][1]*r[1][2] - r[0][2]*r[1][1];
        adj[1][0] = r[1][2]*r[2][0] - r[1][0]*r[2][2];
        adj[1][1] = r[0][0]*r[2][2] - r[0][2]*r[2][0];
        adj[1][2] = r[0][2]*r[1][0] - r[0][0]*r[1][2];
        adj[2][0] = r[1][0]*r[2][1] - r[1][1]*r[2][0];
        adj[2][1] = r[0][1]*r[2][0] - r[0][0]*r[2][1];
        adj[2][2] = r[0][0]*r[1][1] - r[0][1]*r[1][0];
        det = r[0][0]*adj[0][0] + r[0][1]*adj[1][0] + r[0][2]*adj[2][0];
        mag = det[199] ? -det : det;
        sing = (mag == 0) || (mag < {137'd0, thresh});
        if (sing)
        begin
            singulars++;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    res[i][j] = (i == j) ? (32'd1 << FRAC) : 32'd0;
                end
            end
        end
        else
        begin
            p = 0;
            for (int k = 0; k < 200; k++)
            begin
                if (mag[k])
                begin
                    p = k;
                end
            end
            // reciprocal mantissa rounded half up
            q = ((200'd1 << (p + 33)) / mag + 200'd1) >> 1;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod = adj[i][j] * wide_t'(q);
                    if (det[199])
                    begin
                        prod = -prod;
                    end
                    res[i][j] = round_sat(prod, p + 32 - 2*FRAC);
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                acc = sx(res[0][j])*t[0] + sx(res[1][j])*t[1] + sx(res[2][j])*t[2];
                res[3][j] = round_sat(-acc, FRAC);
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            e.row = 2'(k);
            e.c0 = res[k][0];
            e.c1 = res[k][1];
            e.c2 = res[k][2];
            e.singular = sing;
            e.last = (k == 3);
            inv_rows_due.push_back(e);
        end
        inverses++;
    endtask

    task automatic send_row(input logic [1:0] row, input logic [31:0] c0,
                            input logic [31:0] c1, input logic [31:0] c2);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, c2, c1, c0, row};
        do @(posedge clk); while (!s_tready);
        words_sent++;
        mat_store[row*3]   = c0;
        mat_store[row*3+1] = c1;
        mat_store[row*3+2] = c2;
        if (row == 2'd3)
        begin
            predict_inverse();
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (inv_rows_due.size() != 0)
        begin
            @(posedge clk);
        end
        // singular rows need no divide, but allow the full latency anyway
        repeat (120) @(posedge clk);
    endtask

    task automatic write_thresh(input logic [DMIN_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thresh = v;
    endtask

    function automatic logic [31:0] rand_elem(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
            2: return 32'($signed($urandom_range(512)) - 256);
            default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    task automatic send_matrix(input int kind);
        for (int i = 0; i < 4; i++)
        begin
            send_row(2'(i), rand_elem(kind), rand_elem(kind), rand_elem(kind));
        end
    endtask

    task automatic test_directed();
        // trigger with an empty store gives the singular identity
        send_row(2'd3, 32'h0001_0000, 32'hfffe_0000, 32'h0003_8000);
        // identity with translation
        send_row(2'd0, 32'h0001_0000, 32'd0, 32'd0);
        send_row(2'd1, 32'd0, 32'h0001_0000, 32'd0);
        send_row(2'd2, 32'd0, 32'd0, 32'h0001_0000);
        send_row(2'd3, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        // scale by two and by minus one half
        send_row(2'd0, 32'h0002_0000, 32'd0, 32'd0);
        send_row(2'd1, 32'd0, 32'hffff_8000, 32'd0);
        send_row(2'd2, 32'h0000_4000, 32'h0001_0000, 32'h0001_0000);
        send_row(2'd3, 32'h0005_0000, 32'hfff0_0000, 32'h0000_8000);
        // extremes in the linear part, saturation expected
        send_row(2'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
        send_row(2'd1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_row(2'd2, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000);
        send_row(2'd3, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        // tiny entries: determinant below the default threshold
        send_row(2'd0, 32'h0000_0010, 32'd0, 32'd0);
        send_row(2'd1, 32'd0, 32'h0000_0010, 32'd0);
        send_row(2'd2, 32'd0, 32'd0, 32'h0000_0010);
        send_row(2'd3, 32'h0000_0001, 32'd0, 32'd0);
        // repeated row: zero determinant
        send_row(2'd1, 32'h0001_0000, 32'd0, 32'd0);
        send_row(2'd2, 32'h0001_0000, 32'd0, 32'd0);
        send_row(2'd3, 32'd0, 32'd0, 32'd0);
        drain();
    endtask

    task automatic test_thresholds();
        write_thresh('0);
        send_matrix(2);
        send_row(2'd0, 32'd0, 32'd0, 32'd0);
        send_row(2'd3, 32'd7, 32'd0, 32'd0);
        send_matrix(1);
        write_thresh({DMIN_W{1'b1}});
        send_matrix(1);
        send_matrix(0);
        write_thresh(63'd1 << 48);
        for (int n = 0; n < 4; n++)
        begin
            send_matrix(1);
        end
        write_thresh(DET_MIN_RST);
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int n_words);
        int sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(9) < 8)
            begin
                send_matrix($urandom_range(3));
                sent += 4;
            end
            else
            begin
                send_row(2'($urandom_range(3)), rand_elem($urandom_range(3)),
                         rand_elem($urandom_range(3)), rand_elem($urandom_range(3)));
                sent++;
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles = 400;
        for (int n = 0; n < 3; n++)
        begin
            send_matrix(1);
        end
        drain();
    endtask

    // receiver side ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        inv_row_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
        else if (rst_n && m_tvalid && m_tready)
        begin
            if (inv_rows_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h last %b singular %b",
                             m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                e = inv_rows_due.pop_front();
                rows_checked++;
                if (m_tdata[1:0] !== e.row || m_tdata[33:2] !== e.c0
                    || m_tdata[65:34] !== e.c1 || m_tdata[97:66] !== e.c2
                    || m_tdata[103:98] !== 6'd0
                    || m_tuser !== e.singular || m_tlast !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp row %0d %h %h %h sing %b last %b,",
                                  " got %h sing %b last %b"},
                                 e.row, e.c0, e.c1, e.c2, e.singular, e.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        mismatches = 0;
        rows_checked = 0;
        words_sent = 0;
        inverses = 0;
        singulars = 0;
        cycles = 0;
        thresh = DET_MIN_RST;
        for (int k = 0; k < 12; k++)
        begin
            mat_store[k] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_thresholds();
        test_random(0, 0, 60);
        test_random(60, 0, 60);
        test_random(0, 60, 60);
        test_random(7, 7, 60);
        test_backpressure();

        $display("sent %0d words, %0d inverses (%0d singular), checked %0d rows",
                 words_sent, inverses, singulars, rows_checked);
        $display("thresholds zero, maximum, 2^48 and reset value; idle, stall and hold-off phases");
        if (mismatches == 0 && inv_rows_due.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d rows outstanding", mismatches, inv_rows_due.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
